/* sv/sktbl_pkg.sv */
`default_nettype none

package sktbl_pkg;

  localparam int unsigned DEPTH        = 256;
  localparam int unsigned KEY_BYTES    = 8;
  localparam int unsigned VALUE_DIGITS = 10;

  localparam int unsigned KeyW = 8 * KEY_BYTES;
  localparam int unsigned ValW = 4 * VALUE_DIGITS;
  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // port field widths
  localparam int unsigned OpW     = 2;
  localparam int unsigned KeyInW  = 64;
  localparam int unsigned DigitsW = 40;
  localparam int unsigned PosW    = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned SlotW   = 9;
  localparam int unsigned TotalW  = 9;

  // common width for comparing a position against the fill count
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic            cmp;
    logic            ins;
    logic            del;
    logic [CntW-1:0] cnt;
    logic [PosW-1:0] pos;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* sv/sktbl_if.sv */
`default_nettype none

interface sktbl_req_if import sktbl_pkg::*;;
  logic               valid;
  logic               ready;
  logic [OpW-1:0]     operation;
  logic [KeyInW-1:0]  key;
  logic [DigitsW-1:0] phone_digits;
  logic [PosW-1:0]    position;

  modport source (output valid, operation, key, phone_digits, position, input ready);
  modport sink   (input valid, operation, key, phone_digits, position, output ready);
endinterface

interface sktbl_rsp_if import sktbl_pkg::*;;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [SlotW-1:0]   slot;
  logic [DigitsW-1:0] found_digits;
  logic [TotalW-1:0]  entry_total;

  modport source (output valid, status, slot, found_digits, entry_total, input ready);
  modport sink   (input valid, status, slot, found_digits, entry_total, output ready);
endinterface

`default_nettype wire

/* sv/sktbl_cell.sv */
`default_nettype none

module sktbl_cell import sktbl_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [IdxW-1:0] cell_idx_i,
  input  wire cell_ctrl_t      ctrl_i,
  input  wire logic [KeyW-1:0] new_key_i,
  input  wire logic [ValW-1:0] new_val_i,
  input  wire logic [KeyW-1:0] left_key_i,
  input  wire logic [ValW-1:0] left_val_i,
  input  wire logic            left_lt_i,
  input  wire logic [KeyW-1:0] right_key_i,
  input  wire logic [ValW-1:0] right_val_i,
  output logic      [KeyW-1:0] key_o,
  output logic      [ValW-1:0] val_o,
  output logic                 lt_o,
  output logic                 bound_o,
  output logic                 match_o
);

  logic [KeyW-1:0] key_q, key_d;
  logic [ValW-1:0] val_q, val_d;
  logic            lt_q, eq_q;
  logic            occupied;
  logic            at_or_after_pos;

  assign occupied        = CntW'(cell_idx_i) < ctrl_i.cnt;
  assign at_or_after_pos = CmpW'(cell_idx_i) >= CmpW'(ctrl_i.pos);

  // first cell whose key is not below the search key: the lower bound
  assign bound_o = left_lt_i & ~lt_q;
  assign match_o = bound_o & eq_q;

  always_comb begin
    key_d = key_q;
    val_d = val_q;
    if (ctrl_i.ins) begin
      if (bound_o) begin
        key_d = new_key_i;
        val_d = new_val_i;
      end else if (!lt_q) begin
        key_d = left_key_i;
        val_d = left_val_i;
      end
    end else if (ctrl_i.del && at_or_after_pos) begin
      key_d = right_key_i;
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctrl_i.cmp) begin
      lt_q <= occupied && (key_q < new_key_i);
      eq_q <= occupied && (key_q == new_key_i);
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
  end

  assign key_o = key_q;
  assign val_o = val_q;
  assign lt_o  = lt_q;

endmodule

`default_nettype wire

/* sv/sktbl_enc.sv */
`default_nettype none

module sktbl_enc import sktbl_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [DEPTH-1:0]           bound_i,
  input  wire logic [DEPTH-1:0]           match_i,
  input  wire logic [DEPTH-1:0][ValW-1:0] vals_i,
  output logic      [IdxW-1:0]            lb_idx_o,
  output logic                            lb_any_o,
  output logic                            hit_o,
  output logic      [ValW-1:0]            hit_val_o
);

  logic [IdxW-1:0] idx;
  logic            any;
  logic            hit;
  logic [ValW-1:0] hval;

  // bound and match are one-hot or empty, so an OR reduction encodes them
  always_comb begin
    idx  = '0;
    any  = 1'b0;
    hit  = 1'b0;
    hval = '0;
    for (int i = 0; i < DEPTH; i++) begin
      idx  = idx | (bound_i[i] ? IdxW'(i) : '0);
      any  = any | bound_i[i];
      hit  = hit | match_i[i];
      hval = hval | (match_i[i] ? vals_i[i] : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lb_idx_o  <= idx;
      lb_any_o  <= any;
      hit_o     <= hit;
      hit_val_o <= hval;
    end
  end

endmodule

`default_nettype wire

/* sv/sorted_key_table_engine_top.sv */
// From the accepting edge: compare, shift, result; the result step waits while the
// previous result is unread. The cell row handles one operation at a time, compare
// first and the one-position shift of every cell in the next cycle. A new item is
// taken while the previous result still waits in the output register.
// Reset: entry count and control cleared at once; entry storage is not cleared.
`default_nettype none

module sorted_key_table_engine_top import sktbl_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sktbl_req_if.sink   req_i,
  sktbl_rsp_if.source rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD,
    S_FIN
  } state_e;

  state_e              state_q;
  logic [OpW-1:0]      op_q;
  logic [KeyW-1:0]     key_q;
  logic [ValW-1:0]     val_q;
  logic [PosW-1:0]     pos_q;
  logic [CntW-1:0]     cnt_q;
  logic                fail_q;

  logic                rsp_valid_q;
  logic [StatusW-1:0]  rsp_status_q;
  logic [SlotW-1:0]    rsp_slot_q;
  logic [DigitsW-1:0]  rsp_digits_q;
  logic [TotalW-1:0]   rsp_total_q;

  logic                is_ins, is_del;
  logic                full, pos_ok;
  cell_ctrl_t          ctrl;

  logic [DEPTH-1:0][KeyW-1:0] key_c;
  logic [DEPTH-1:0][ValW-1:0] val_c;
  logic [DEPTH-1:0]           lt_c;
  logic [DEPTH-1:0]           bound_c;
  logic [DEPTH-1:0]           match_c;

  logic [IdxW-1:0]     lb_idx;
  logic                lb_any;
  logic                hit;
  logic [ValW-1:0]     hit_val;
  logic [CntW-1:0]     lb;

  assign is_ins = op_q == OP_INSERT;
  assign is_del = op_q == OP_DELETE;
  assign full   = cnt_q == CntW'(DEPTH);
  assign pos_ok = CmpW'(pos_q) < CmpW'(cnt_q);

  assign ctrl.cmp = state_q == S_CMP;
  assign ctrl.ins = (state_q == S_UPD) && is_ins && !full;
  assign ctrl.del = (state_q == S_UPD) && is_del && pos_ok;
  assign ctrl.cnt = cnt_q;
  assign ctrl.pos = pos_q;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KeyW-1:0] left_key, right_key;
    logic [ValW-1:0] left_val, right_val;
    logic            left_lt;

    if (g == 0) begin : g_first
      assign left_key = key_q;
      assign left_val = val_q;
      assign left_lt  = 1'b1;
    end else begin : g_mid
      assign left_key = key_c[g-1];
      assign left_val = val_c[g-1];
      assign left_lt  = lt_c[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_key = key_c[g];
      assign right_val = val_c[g];
    end else begin : g_inner
      assign right_key = key_c[g+1];
      assign right_val = val_c[g+1];
    end

    sktbl_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cell_idx_i  (IdxW'(g)),
      .ctrl_i      (ctrl),
      .new_key_i   (key_q),
      .new_val_i   (val_q),
      .left_key_i  (left_key),
      .left_val_i  (left_val),
      .left_lt_i   (left_lt),
      .right_key_i (right_key),
      .right_val_i (right_val),
      .key_o       (key_c[g]),
      .val_o       (val_c[g]),
      .lt_o        (lt_c[g]),
      .bound_o     (bound_c[g]),
      .match_o     (match_c[g])
    );
  end

  sktbl_enc u_enc (
    .clk_i     (clk_i),
    .en_i      (state_q == S_UPD),
    .bound_i   (bound_c),
    .match_i   (match_c),
    .vals_i    (val_c),
    .lb_idx_o  (lb_idx),
    .lb_any_o  (lb_any),
    .hit_o     (hit),
    .hit_val_o (hit_val)
  );

  // no boundary only when every cell holds a smaller key, i.e. a full table
  assign lb = lb_any ? CntW'(lb_idx) : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      // in S_FIN the result register is handled by the state itself
      if (rsp_valid_q && rsp_o.ready && state_q != S_FIN) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (ctrl.ins) begin
            cnt_q <= cnt_q + CntW'(1);
          end else if (ctrl.del) begin
            cnt_q <= cnt_q - CntW'(1);
          end
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_i.valid) begin
      op_q  <= req_i.operation;
      key_q <= req_i.key[KeyW-1:0];
      val_q <= req_i.phone_digits[ValW-1:0];
      pos_q <= req_i.position;
    end
    if (state_q == S_UPD) begin
      fail_q <= (is_ins && full) || (is_del && !pos_ok);
    end
    if (state_q == S_FIN && (!rsp_valid_q || rsp_o.ready)) begin
      rsp_total_q  <= TotalW'(cnt_q);
      rsp_digits_q <= '0;
      case (op_q)
        OP_INSERT: begin
          rsp_status_q <= fail_q ? ST_FULL : ST_OK;
          rsp_slot_q   <= SlotW'(lb);
        end
        OP_DELETE: begin
          rsp_status_q <= fail_q ? ST_BAD_POS : ST_OK;
          rsp_slot_q   <= SlotW'(pos_q);
        end
        default: begin
          rsp_status_q <= hit ? ST_OK : ST_NOT_FOUND;
          rsp_slot_q   <= SlotW'(lb);
          if (hit) begin
            rsp_digits_q <= DigitsW'(hit_val);
          end
        end
      endcase
    end
  end

  assign req_i.ready        = state_q == S_IDLE;
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.slot         = rsp_slot_q;
  assign rsp_o.found_digits = rsp_digits_q;
  assign rsp_o.entry_total  = rsp_total_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("entry count above table depth");

  a_bound_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> $onehot0(bound_c))
    else $error("more than one lower-bound cell");

  a_bound_exists: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && !full) |-> $onehot(bound_c))
    else $error("no lower-bound cell in a table with free space");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("insert did not grow the table by one");

endmodule

`default_nettype wire
